>>> rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

    // Configuration port geometry: seven 64-bit registers at byte address 8*i
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // Register indexes (paddr[5:3])
    localparam logic [2:0] REG_MATCH_MODE     = 3'd0;
    localparam logic [2:0] REG_SEARCH_LENGTH  = 3'd1;
    localparam logic [2:0] REG_REPLACE_LENGTH = 3'd2;
    localparam logic [2:0] REG_SEARCH_LOW     = 3'd3;
    localparam logic [2:0] REG_SEARCH_HIGH    = 3'd4;
    localparam logic [2:0] REG_REPLACE_LOW    = 3'd5;
    localparam logic [2:0] REG_REPLACE_HIGH   = 3'd6;

    // Pattern geometry
    localparam int          PAT_BYTES = 16;
    localparam int          LEN_W     = 5;
    localparam logic [4:0]  PAT_MAX_LEN = 5'd16;

    // Input opcodes
    localparam logic OP_TEXT  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Match modes
    localparam logic MODE_SUBSTRING = 1'b0;
    localparam logic MODE_WORD      = 1'b1;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef struct packed {
        logic       opcode;
        logic [7:0] text_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_word_t;

    // Whitespace: tab through carriage return, and space
    function automatic logic is_ws(input logic [7:0] b);
        return (b inside {8'd32, [8'd9:8'd13]});
    endfunction

endpackage

`default_nettype wire

>>> rtl/stream_find_replace.sv
`default_nettype none

// Streaming find-and-replace over a byte stream. One word in carries a text
// byte or a flush; the block answers with zero or more bytes (at most seventeen
// unless the pattern is changed while bytes are held), the final one marked by
// last_of_run. The block takes one word at a time: it accepts, then steps a small
// sequencer until every byte that word causes has been handed to the output
// register, and only then raises item_ready again. Output back-pressure stalls
// the sequencer while a byte cannot be staged. The rescans of the held prefix
// all go through one shared prefix comparator that checks the held bytes
// against the search pattern combinationally.
// Configure through the APB port only while the block is idle.
module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int PATTERN_MAX = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // item channel
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire in_word_t              item,
    // result channel
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output out_word_t                  result,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int HOLD_LIMIT = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
    localparam int CNT_W      = $clog2(HOLD_LIMIT + 1);
    localparam int IDX_W      = $clog2(HOLD_LIMIT);
    localparam logic [LEN_W-1:0] HOLD_LIMIT_LEN = LEN_W'(HOLD_LIMIT);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TRIM  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_REPL  = 4'd3;
    localparam logic [3:0] ST_DRAIN = 4'd4;
    localparam logic [3:0] ST_BYTE  = 4'd5;
    localparam logic [3:0] ST_WORD  = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                  match_mode_reg;
    logic [LEN_W-1:0]      search_length_reg;
    logic [LEN_W-1:0]      replace_length_reg;
    logic [CFG_DATA_W-1:0] search_low_reg;
    logic [CFG_DATA_W-1:0] search_high_reg;
    logic [CFG_DATA_W-1:0] replace_low_reg;
    logic [CFG_DATA_W-1:0] replace_high_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[CFG_ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_mode_reg     <= MODE_SUBSTRING;
            search_length_reg  <= LEN_W'(1);
            replace_length_reg <= '0;
            search_low_reg     <= '0;
            search_high_reg    <= '0;
            replace_low_reg    <= '0;
            replace_high_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MATCH_MODE:     match_mode_reg     <= pwdata[0];
                REG_SEARCH_LENGTH:  search_length_reg  <= pwdata[LEN_W-1:0];
                REG_REPLACE_LENGTH: replace_length_reg <= pwdata[LEN_W-1:0];
                REG_SEARCH_LOW:     search_low_reg     <= pwdata;
                REG_SEARCH_HIGH:    search_high_reg    <= pwdata;
                REG_REPLACE_LOW:    replace_low_reg    <= pwdata;
                REG_REPLACE_HIGH:   replace_high_reg   <= pwdata;
                default:            ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (cfg_index)
            REG_MATCH_MODE:     prdata = CFG_DATA_W'(match_mode_reg);
            REG_SEARCH_LENGTH:  prdata = CFG_DATA_W'(search_length_reg);
            REG_REPLACE_LENGTH: prdata = CFG_DATA_W'(replace_length_reg);
            REG_SEARCH_LOW:     prdata = search_low_reg;
            REG_SEARCH_HIGH:    prdata = search_high_reg;
            REG_REPLACE_LOW:    prdata = replace_low_reg;
            REG_REPLACE_HIGH:   prdata = replace_high_reg;
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pattern views and effective lengths
    // ------------------------------------------------------------------
    logic [PAT_BYTES-1:0][7:0] search_pat;
    logic [PAT_BYTES-1:0][7:0] replace_pat;
    logic [LEN_W-1:0]          search_len;
    logic [LEN_W-1:0]          replace_len;

    assign search_pat  = {search_high_reg, search_low_reg};
    assign replace_pat = {replace_high_reg, replace_low_reg};
    assign search_len  = (search_length_reg > HOLD_LIMIT_LEN) ? HOLD_LIMIT_LEN
                                                              : search_length_reg;
    assign replace_len = (replace_length_reg > PAT_MAX_LEN) ? PAT_MAX_LEN
                                                            : replace_length_reg;

    // ------------------------------------------------------------------
    // Sequencer, held bytes and output staging registers
    // ------------------------------------------------------------------
    logic [3:0]       state_reg,      state_next;
    logic [7:0]       byte_reg,       byte_next;
    logic             emit_b_reg,     emit_b_next;
    logic             too_long_reg,   too_long_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [LEN_W-1:0] ridx_reg,       ridx_next;
    logic [7:0]       held_reg  [HOLD_LIMIT];
    logic [7:0]       held_next [HOLD_LIMIT];
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_byte_reg,  pend_byte_next;
    logic             out_valid_reg,  out_valid_next;
    out_word_t        out_reg,        out_next;

    logic [LEN_W-1:0] count_len;
    logic             prefix_ok;
    logic             out_free;
    logic             can_push;
    logic             emit_req;
    logic [7:0]       emit_byte;
    logic             release_req;

    assign count_len = LEN_W'(count_reg);
    assign out_free  = !out_valid_reg || result_ready;
    assign can_push  = !pend_valid_reg || out_free;

    // Shared prefix comparator: held bytes below count against the pattern
    always_comb
    begin
        prefix_ok = (count_len <= search_len);
        for (int i = 0; i < HOLD_LIMIT; i++)
        begin
            if ((LEN_W'(i) < count_len) && (held_reg[i] != search_pat[i]))
            begin
                prefix_ok = 1'b0;
            end
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        byte_next     = byte_reg;
        emit_b_next   = emit_b_reg;
        too_long_next = too_long_reg;
        count_next    = count_reg;
        ridx_next     = ridx_reg;
        held_next     = held_reg;
        emit_req      = 1'b0;
        emit_byte     = byte_reg;
        release_req   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    byte_next = item.text_byte;
                    if (item.opcode == OP_FLUSH)
                    begin
                        emit_b_next = 1'b0;
                        if (match_mode_reg == MODE_WORD)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            too_long_next = 1'b0;
                            state_next    = ST_DRAIN;
                        end
                    end
                    else if (match_mode_reg == MODE_SUBSTRING)
                    begin
                        too_long_next = 1'b0;
                        if (search_len == '0)
                        begin
                            emit_b_next = 1'b1;
                            state_next  = ST_DRAIN;
                        end
                        else
                        begin
                            emit_b_next = 1'b0;
                            state_next  = ST_TRIM;
                        end
                    end
                    else if (is_ws(item.text_byte))
                    begin
                        emit_b_next = 1'b1;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_WORD;
                    end
                end
            end

            // Make room, then append the new byte
            ST_TRIM:
            begin
                if (count_len >= search_len)
                begin
                    release_req = 1'b1;
                end
                else
                begin
                    held_next[count_reg[IDX_W-1:0]] = byte_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_SCAN;
                end
            end

            // Drop front bytes until the held run is a pattern prefix
            ST_SCAN:
            begin
                if ((count_reg != '0) && !prefix_ok)
                begin
                    release_req = 1'b1;
                end
                else if (count_len == search_len)
                begin
                    count_next = '0;
                    ridx_next  = '0;
                    state_next = ST_REPL;
                end
                else if (byte_reg == NEWLINE_BYTE)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_REPL:
            begin
                if (ridx_reg < replace_len)
                begin
                    emit_req  = 1'b1;
                    emit_byte = replace_pat[ridx_reg[3:0]];
                    if (can_push)
                    begin
                        ridx_next = ridx_reg + LEN_W'(1);
                    end
                end
                else
                begin
                    state_next = emit_b_reg ? ST_BYTE : ST_DONE;
                end
            end

            ST_DRAIN:
            begin
                if (count_reg != '0)
                begin
                    release_req = 1'b1;
                end
                else
                begin
                    state_next = emit_b_reg ? ST_BYTE : ST_DONE;
                end
            end

            ST_BYTE:
            begin
                emit_req  = 1'b1;
                emit_byte = byte_reg;
                if (can_push)
                begin
                    state_next = ST_DONE;
                end
            end

            // Word byte: extend the candidate or give up on this word
            ST_WORD:
            begin
                if (!too_long_reg && (count_len < search_len) && prefix_ok
                    && (search_pat[count_len[3:0]] == byte_reg))
                begin
                    held_next[count_reg[IDX_W-1:0]] = byte_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    too_long_next = 1'b1;
                    emit_b_next   = 1'b1;
                    state_next    = ST_DRAIN;
                end
            end

            // End of word: replace on a full match, else release
            ST_FIN:
            begin
                too_long_next = 1'b0;
                if (!too_long_reg && (search_len != '0) && (count_len == search_len)
                    && prefix_ok)
                begin
                    count_next = '0;
                    ridx_next  = '0;
                    state_next = ST_REPL;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DONE:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Release the front held byte: emit it and shift the rest down
        if (release_req)
        begin
            emit_req  = 1'b1;
            emit_byte = held_reg[0];
            if (can_push)
            begin
                for (int i = 0; i < HOLD_LIMIT - 1; i++)
                begin
                    held_next[i] = held_reg[i + 1];
                end
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // Output staging: one byte lags in pend so the final one can be marked
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !result_ready;

        if (emit_req && can_push)
        begin
            if (pend_valid_reg)
            begin
                out_next.out_byte    = pend_byte_reg;
                out_next.last_of_run = 1'b0;
                out_valid_next       = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
        end
        else if ((state_reg == ST_DONE) && pend_valid_reg && out_free)
        begin
            out_next.out_byte    = pend_byte_reg;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
            pend_valid_next      = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            emit_b_reg     <= 1'b0;
            too_long_reg   <= 1'b0;
            count_reg      <= '0;
            ridx_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            emit_b_reg     <= emit_b_next;
            too_long_reg   <= too_long_next;
            count_reg      <= count_next;
            ridx_reg       <= ridx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        held_reg      <= held_next;
        pend_byte_reg <= pend_byte_next;
        out_reg       <= out_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No byte is left staged between words
    a_pend_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !pend_valid_reg)
        else $error("staged byte left over when idle");

    // Held run never outgrows the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_len <= HOLD_LIMIT_LEN)
        else $error("held count exceeds store depth");

    // One word at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("accepted a word while still busy");

    // Replacement index stays within the pattern
    a_ridx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPL) |-> (ridx_reg <= replace_len))
        else $error("replacement index out of range");

endmodule

`default_nettype wire

>>> tb/stream_find_replace_test.sv
`timescale 1ns / 100ps

module stream_find_replace_test;

    import sfr_pkg::*;

    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 22;
    localparam int QUIET_CYCLES = 64;
    localparam int STALL_LIMIT  = 4000;
    localparam int NUM_ROWS     = 33;
    localparam int MAX_REPORTS  = 10;

    // Row kinds of the directed plan
    typedef enum logic [1:0] {
        ROW_CFG,        // register write
        ROW_CHECKED,    // word whose output comes from the rewrite model
        ROW_NO_OUT,     // word that must produce nothing
        ROW_ECHO        // word that must come back unchanged, alone
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        in_word_t    word;
        logic [2:0]  idx;
        logic [63:0] value;
    } plan_row_t;

    // DUT signals
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    in_word_t              item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_word_t             result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Register mirror, at reset values
    logic        cfg_mode       = MODE_SUBSTRING;
    logic [4:0]  cfg_search_len = 5'd1;
    logic [4:0]  cfg_repl_len   = 5'd0;
    logic [63:0] cfg_search_lo  = '0;
    logic [63:0] cfg_search_hi  = '0;
    logic [63:0] cfg_repl_lo    = '0;
    logic [63:0] cfg_repl_hi    = '0;

    // Rewrite model state
    logic [7:0]  held [PAT_BYTES];
    int          held_n       = 0;
    bit          word_spoiled = 1'b0;
    out_word_t   rewrite_out [$];

    // Bytes still owed by the block, oldest first
    out_word_t   pending_out [$];
    in_word_t    text_feed [$];
    plan_row_t   plan [NUM_ROWS];

    int          bad_words     = 0;
    int          stall_cycles  = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          stream_busy   = 1'b0;

    stream_find_replace u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Rewrite model
    // ---------------------------------------------------------------

    function automatic logic [7:0] search_at(int i);
        logic [63:0] w;
        w = (i < 8) ? cfg_search_lo : cfg_search_hi;
        return w[(i % 8) * 8 +: 8];
    endfunction

    function automatic logic [7:0] replace_at(int i);
        logic [63:0] w;
        w = (i < 8) ? cfg_repl_lo : cfg_repl_hi;
        return w[(i % 8) * 8 +: 8];
    endfunction

    // Oversized lengths saturate at the hold depth
    function automatic int search_len();
        return (cfg_search_len > PAT_BYTES) ? PAT_BYTES : int'(cfg_search_len);
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic bit held_matches(int count, int s);
        if (count > s)
            return 1'b0;
        for (int i = 0; i < count; i++)
            if (held[i] != search_at(i))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        out_word_t o;
        o.out_byte    = b;
        o.last_of_run = 1'b0;
        rewrite_out.push_back(o);
    endfunction

    function automatic void shift_out_front();
        if (held_n == 0)
            return;
        put_byte(held[0]);
        for (int i = 0; i < held_n - 1; i++)
            held[i] = held[i + 1];
        held_n--;
    endfunction

    function automatic void drain_held();
        for (int i = 0; i < held_n; i++)
            put_byte(held[i]);
        held_n = 0;
    endfunction

    function automatic void put_replacement();
        int r;
        r = (cfg_repl_len > 5'd16) ? 16 : int'(cfg_repl_len);
        for (int i = 0; i < r; i++)
            put_byte(replace_at(i));
    endfunction

    // End of a word: replace it if it is exactly the pattern
    function automatic void close_word();
        int s;
        s = search_len();
        if (!word_spoiled && s > 0 && held_n == s && held_matches(s, s))
        begin
            held_n = 0;
            put_replacement();
        end
        else
            drain_held();
    endfunction

    function automatic void substring_step(logic [7:0] b);
        int s;
        s = search_len();
        word_spoiled = 1'b0;
        if (s == 0)
        begin
            drain_held();
            put_byte(b);
            return;
        end
        // held bytes are rechecked in case the pattern changed
        while (held_n >= s)
            shift_out_front();
        held[held_n] = b;
        held_n++;
        while (held_n > 0 && !held_matches(held_n, s))
            shift_out_front();
        if (held_n == s)
        begin
            held_n = 0;
            put_replacement();
        end
        // matches never cross a newline
        if (b == NEWLINE_BYTE)
            drain_held();
    endfunction

    function automatic void word_step(logic [7:0] b);
        int s;
        s = search_len();
        if (is_blank(b))
        begin
            close_word();
            put_byte(b);
            word_spoiled = 1'b0;
        end
        else if (!word_spoiled && held_n < s && held_matches(held_n, s)
                 && search_at(held_n) == b)
        begin
            held[held_n] = b;
            held_n++;
        end
        else
        begin
            drain_held();
            put_byte(b);
            word_spoiled = 1'b1;
        end
    endfunction

    function automatic void rewrite_step(in_word_t w);
        rewrite_out.delete();
        if (w.opcode == OP_FLUSH)
        begin
            if (cfg_mode == MODE_WORD)
                close_word();
            else
                drain_held();
            word_spoiled = 1'b0;
        end
        else if (cfg_mode == MODE_WORD)
            word_step(w.text_byte);
        else
            substring_step(w.text_byte);
        if (rewrite_out.size() > 0)
            rewrite_out[rewrite_out.size() - 1].last_of_run = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic in_word_t text_word(logic op, logic [7:0] b);
        in_word_t w;
        w.opcode    = op;
        w.text_byte = b;
        return w;
    endfunction

    function automatic plan_row_t feed_row(row_kind_t k, logic op, logic [7:0] b);
        plan_row_t r;
        r      = '0;
        r.kind = k;
        r.word = text_word(op, b);
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [2:0] idx, logic [63:0] value);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    function automatic logic [7:0] pick_blank();
        int v;
        v = $urandom_range(0, 5);
        return (v == 5) ? 8'd32 : 8'(9 + v);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 8'("a" + $urandom_range(0, 2));
        else if (r < 50)
            return pick_blank();
        else if (r < 55)
            return NEWLINE_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Small alphabet so that patterns overlap with themselves and the text
    function automatic logic [63:0] pattern_word();
        logic [63:0] w;
        int r;
        for (int i = 0; i < 8; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                w[i * 8 +: 8] = 8'("a" + $urandom_range(0, 2));
            else if (r < 85)
                w[i * 8 +: 8] = NEWLINE_BYTE;
            else
                w[i * 8 +: 8] = 8'($urandom_range(0, 255));
        end
        return w;
    endfunction

    // Mostly whole patterns and broken prefixes, the rest noise and flushes
    task automatic build_feed(int count);
        int s;
        int r;
        int k;
        s = search_len();
        text_feed.delete();
        while (text_feed.size() < count)
        begin
            r = $urandom_range(0, 99);
            if (s > 0 && r < 40)
            begin
                for (int i = 0; i < s; i++)
                    text_feed.push_back(text_word(OP_TEXT, search_at(i)));
                if (cfg_mode == MODE_WORD && $urandom_range(0, 9) < 7)
                    text_feed.push_back(text_word(OP_TEXT, pick_blank()));
            end
            else if (s > 1 && r < 55)
            begin
                k = $urandom_range(1, s - 1);
                for (int i = 0; i < k; i++)
                    text_feed.push_back(text_word(OP_TEXT, search_at(i)));
                text_feed.push_back(text_word(OP_TEXT, pick_text_byte()));
            end
            else if (r < 62)
                text_feed.push_back(text_word(OP_FLUSH, 8'($urandom_range(0, 255))));
            else
                text_feed.push_back(text_word(OP_TEXT, pick_text_byte()));
        end
    endtask

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Wait for the block to go quiet after stream traffic
    task automatic drain_block();
        if (stream_busy)
        begin
            item_valid <= 1'b0;
            while (pending_out.size() != 0)
                @(posedge clk);
            repeat (QUIET_CYCLES) @(posedge clk);
            stream_busy = 1'b0;
        end
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
        drain_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MATCH_MODE:     cfg_mode       = value[0];
            REG_SEARCH_LENGTH:  cfg_search_len = value[4:0];
            REG_REPLACE_LENGTH: cfg_repl_len   = value[4:0];
            REG_SEARCH_LOW:     cfg_search_lo  = value;
            REG_SEARCH_HIGH:    cfg_search_hi  = value;
            REG_REPLACE_LOW:    cfg_repl_lo    = value;
            REG_REPLACE_HIGH:   cfg_repl_hi    = value;
            default: ;
        endcase
    endtask

    task automatic send_item(in_word_t w, row_kind_t k);
        out_word_t o;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (!item_ready);
        stream_busy = 1'b1;
        // model always steps so its state follows the block
        rewrite_step(w);
        case (k)
            ROW_CHECKED:
                foreach (rewrite_out[i])
                    pending_out.push_back(rewrite_out[i]);
            ROW_ECHO:
            begin
                o.out_byte    = w.text_byte;
                o.last_of_run = 1'b1;
                pending_out.push_back(o);
            end
            default: ;
        endcase
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Result check against the oldest owed byte
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_out.size() == 0)
            begin
                if (bad_words < MAX_REPORTS)
                    $display("unexpected word: out_byte %h last_of_run %b",
                             result.out_byte, result.last_of_run);
                bad_words++;
            end
            else
            begin
                if (result.out_byte != pending_out[0].out_byte
                    || result.last_of_run != pending_out[0].last_of_run)
                begin
                    if (bad_words < MAX_REPORTS)
                        $display("mismatch: out_byte exp %h got %h, last_of_run exp %b got %b",
                                 pending_out[0].out_byte, result.out_byte,
                                 pending_out[0].last_of_run, result.last_of_run);
                    bad_words++;
                end
                void'(pending_out.pop_front());
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || psel || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial
    begin
        logic [4:0] slen;
        logic [4:0] rlen;
        logic       mode;

        // directed plan: reset values first, then substring and word cases
        plan = '{
            feed_row(ROW_ECHO,    OP_TEXT,  "A"),
            feed_row(ROW_NO_OUT,  OP_TEXT,  8'h00),
            feed_row(ROW_ECHO,    OP_TEXT,  8'hFF),
            feed_row(ROW_NO_OUT,  OP_FLUSH, 8'hFF),
            reg_row(REG_SEARCH_LOW,     64'h0000_0000_0063_6261),
            reg_row(REG_SEARCH_LENGTH,  64'd3),
            reg_row(REG_REPLACE_LOW,    64'h4847_4645_4443_4241),
            reg_row(REG_REPLACE_HIGH,   64'h504F_4E4D_4C4B_4A49),
            reg_row(REG_REPLACE_LENGTH, 64'd16),
            // full match to the longest replacement
            feed_row(ROW_CHECKED, OP_TEXT,  "a"),
            feed_row(ROW_CHECKED, OP_TEXT,  "b"),
            feed_row(ROW_CHECKED, OP_TEXT,  "c"),
            // newline releases a partial match
            feed_row(ROW_CHECKED, OP_TEXT,  "a"),
            feed_row(ROW_CHECKED, OP_TEXT,  "b"),
            feed_row(ROW_CHECKED, OP_TEXT,  NEWLINE_BYTE),
            // rescan after a broken prefix
            feed_row(ROW_CHECKED, OP_TEXT,  "a"),
            feed_row(ROW_CHECKED, OP_TEXT,  "a"),
            feed_row(ROW_CHECKED, OP_TEXT,  "b"),
            feed_row(ROW_CHECKED, OP_TEXT,  "c"),
            // leave a prefix held across a mode change
            feed_row(ROW_CHECKED, OP_TEXT,  "a"),
            feed_row(ROW_CHECKED, OP_TEXT,  "b"),
            reg_row(REG_MATCH_MODE,     64'(MODE_WORD)),
            reg_row(REG_REPLACE_LENGTH, 64'd31),
            feed_row(ROW_CHECKED, OP_TEXT,  " "),
            feed_row(ROW_CHECKED, OP_TEXT,  "a"),
            feed_row(ROW_CHECKED, OP_TEXT,  "b"),
            feed_row(ROW_CHECKED, OP_TEXT,  "c"),
            feed_row(ROW_CHECKED, OP_TEXT,  " "),
            // oversized, then zero, search length with a byte held
            reg_row(REG_SEARCH_LENGTH,  64'd31),
            feed_row(ROW_CHECKED, OP_TEXT,  "a"),
            reg_row(REG_SEARCH_LENGTH,  64'd0),
            feed_row(ROW_CHECKED, OP_TEXT,  " "),
            feed_row(ROW_ECHO,    OP_TEXT,  "b")
        };

        for (int i = 0; i < PAT_BYTES; i++)
            held[i] = 8'h00;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 87;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                cfg_write(plan[i].idx, plan[i].value);
            else
                send_item(plan[i].word, plan[i].kind);
        end

        // random phases, extremes of the lengths first
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p * 3 / NUM_PHASES)
                0:       begin send_idle_pct = 18; recv_idle_pct = 87; end
                1:       begin send_idle_pct = 87; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            mode = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
            case (p)
                0:       begin slen = 5'd1;  rlen = 5'd0;  end
                1:       begin slen = 5'd16; rlen = 5'd16; end
                2:       begin slen = 5'd31; rlen = 5'd31; end
                3:       begin slen = 5'd0;  rlen = 5'($urandom_range(0, 16)); end
                default: begin slen = 5'($urandom_range(1, 5));
                               rlen = 5'($urandom_range(0, 16)); end
            endcase
            cfg_write(REG_MATCH_MODE,     64'(mode));
            cfg_write(REG_SEARCH_LENGTH,  64'(slen));
            cfg_write(REG_REPLACE_LENGTH, 64'(rlen));
            cfg_write(REG_SEARCH_LOW,     pattern_word());
            cfg_write(REG_SEARCH_HIGH,    pattern_word());
            cfg_write(REG_REPLACE_LOW,    {$urandom, $urandom});
            cfg_write(REG_REPLACE_HIGH,   {$urandom, $urandom});
            build_feed(PHASE_ITEMS);
            foreach (text_feed[i])
                send_item(text_feed[i], ROW_CHECKED);
        end

        stream_busy = 1'b1;
        drain_block();

        if (bad_words == 0 && pending_out.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
